### sv/bmh_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the binary min-heap priority queue.
// No dependencies; used by the controller, the datapath and the top level.

package bmh_pkg;

  localparam int CAPACITY  = 64;
  localparam int KEY_WIDTH = 32;
  localparam int KEY_IO_W  = 32;
  localparam int COUNT_IO_W = 7;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // Child indices reach 2 * CAPACITY, so they need two bits more than an index.
  localparam int CHILD_W = IDX_W + 2;

  typedef logic signed [KEY_WIDTH-1:0] key_t;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } stat_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_PUSH_START,
    DP_READ_ROOT,
    DP_FINISH,
    DP_PEEK_TAKE,
    DP_POP_TAKE,
    DP_SU_READ,
    DP_SU_STEP,
    DP_SD_READ,
    DP_SD_STEP,
    DP_WRITE_CUR,
    DP_LOAD_OUT
  } dp_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT,
    ST_SU_RD,
    ST_SU_CMP,
    ST_SD_RD,
    ST_SD_CMP,
    ST_RESP
  } state_e;

  typedef struct packed {
    dp_op_e op;
    stat_e  status;
  } ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_zero;
    logic su_move;
    logic sd_leaf;
    logic sd_move;
  } dp_stat_t;

endpackage

### sv/bmh_datapath.sv
`timescale 1ns / 1ps
// Datapath of the min-heap: key store memory, moving key, position and count,
// result and output registers. Depends on bmh_pkg.

module bmh_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bmh_pkg::ctl_t                    ctl_i,
  input  logic signed [bmh_pkg::KEY_IO_W-1:0] key_in_i,
  output bmh_pkg::dp_stat_t                stat_o,
  output logic signed [bmh_pkg::KEY_IO_W-1:0] key_out_o,
  output logic [1:0]                       status_o,
  output logic [bmh_pkg::COUNT_IO_W-1:0]   entry_count_o
);
  import bmh_pkg::*;

  key_t mem [CAPACITY];
  key_t rd_a_q, rd_b_q;

  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  key_t             cur_key_q, cur_key_d;
  key_t             res_key_q, res_key_d;
  stat_e            res_status_q, res_status_d;

  key_t                  out_key_q;
  stat_e                 out_status_q;
  logic [CNT_W-1:0]      out_count_q;

  logic             mem_we;
  logic [IDX_W-1:0] wr_addr;
  key_t             wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr_a, rd_addr_b;
  logic             load_out;

  logic [IDX_W-1:0]   parent;
  logic [IDX_W:0]     lo;
  logic [CHILD_W-1:0] hi;
  logic               hi_ok;
  logic               a_lt, b_lt;
  key_t               pick_key, move_key;
  logic [IDX_W-1:0]   pick_idx;

  assign parent = IDX_W'((pos_q - IDX_W'(1)) >> 1);
  assign lo     = {pos_q, 1'b1};
  assign hi     = CHILD_W'(lo) + CHILD_W'(1);
  assign hi_ok  = hi < CHILD_W'(count_q);

  // Sift-down picks the smaller child; the left child wins a tie.
  assign a_lt     = rd_a_q < cur_key_q;
  assign pick_key = a_lt ? rd_a_q : cur_key_q;
  assign b_lt     = hi_ok && (rd_b_q < pick_key);
  assign move_key = b_lt ? rd_b_q : rd_a_q;
  assign pick_idx = b_lt ? hi[IDX_W-1:0] : lo[IDX_W-1:0];

  assign stat_o.full     = count_q == CNT_W'(CAPACITY);
  assign stat_o.empty    = count_q == '0;
  assign stat_o.pos_zero = pos_q == '0;
  assign stat_o.su_move  = cur_key_q < rd_a_q;
  assign stat_o.sd_leaf  = CHILD_W'(lo) >= CHILD_W'(count_q);
  assign stat_o.sd_move  = a_lt || b_lt;

  always_comb begin
    mem_we       = 1'b0;
    wr_addr      = pos_q;
    wr_data      = cur_key_q;
    rd_en        = 1'b0;
    rd_addr_a    = '0;
    rd_addr_b    = '0;
    load_out     = 1'b0;
    count_d      = count_q;
    pos_d        = pos_q;
    cur_key_d    = cur_key_q;
    res_key_d    = res_key_q;
    res_status_d = res_status_q;
    case (ctl_i.op)
      DP_PUSH_START: begin
        cur_key_d    = KEY_WIDTH'(key_in_i);
        pos_d        = IDX_W'(count_q);
        count_d      = count_q + CNT_W'(1);
        res_key_d    = '0;
        res_status_d = STAT_OK;
      end
      DP_READ_ROOT: begin
        rd_en        = 1'b1;
        rd_addr_a    = '0;
        rd_addr_b    = IDX_W'(count_q - CNT_W'(1));
        res_status_d = STAT_OK;
      end
      DP_FINISH: begin
        res_key_d    = '0;
        res_status_d = ctl_i.status;
      end
      DP_PEEK_TAKE: begin
        res_key_d = rd_a_q;
      end
      DP_POP_TAKE: begin
        // The last entry becomes the moving key and starts at the root.
        res_key_d = rd_a_q;
        cur_key_d = rd_b_q;
        count_d   = count_q - CNT_W'(1);
        pos_d     = '0;
      end
      DP_SU_READ: begin
        rd_en     = 1'b1;
        rd_addr_a = parent;
      end
      DP_SU_STEP: begin
        mem_we = 1'b1;
        if (stat_o.su_move) begin
          wr_data = rd_a_q;
          pos_d   = parent;
        end
      end
      DP_SD_READ: begin
        rd_en     = 1'b1;
        rd_addr_a = lo[IDX_W-1:0];
        rd_addr_b = hi[IDX_W-1:0];
      end
      DP_SD_STEP: begin
        mem_we = 1'b1;
        if (stat_o.sd_move) begin
          wr_data = move_key;
          pos_d   = pick_idx;
        end
      end
      DP_WRITE_CUR: begin
        mem_we = 1'b1;
      end
      DP_LOAD_OUT: begin
        load_out = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_q <= mem[rd_addr_a];
      rd_b_q <= mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    cur_key_q    <= cur_key_d;
    res_key_q    <= res_key_d;
    res_status_q <= res_status_d;
    if (load_out) begin
      out_key_q    <= res_key_q;
      out_status_q <= res_status_q;
      out_count_q  <= count_q;
    end
  end

  assign key_out_o     = KEY_IO_W'(out_key_q);
  assign status_o      = out_status_q;
  assign entry_count_o = COUNT_IO_W'(out_count_q);

endmodule

### sv/bmh_ctrl.sv
`timescale 1ns / 1ps
// Controller of the min-heap: command decode and the sift-up / sift-down
// sequencing, plus the output valid flag. Depends on bmh_pkg.

module bmh_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        command_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  bmh_pkg::dp_stat_t stat_i,
  output bmh_pkg::ctl_t     ctl_o
);
  import bmh_pkg::*;

  state_e state_q, state_d;
  logic   is_pop_q, is_pop_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d  = state_q;
    is_pop_d = is_pop_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          is_pop_d = command_i == CMD_POP;
          case (command_i)
            CMD_PUSH:          state_d = stat_i.full ? ST_RESP : ST_SU_RD;
            CMD_POP, CMD_PEEK: state_d = stat_i.empty ? ST_RESP : ST_ROOT;
            default:           state_d = ST_RESP;
          endcase
        end
      end
      ST_ROOT:   state_d = is_pop_q ? ST_SD_RD : ST_RESP;
      ST_SU_RD:  state_d = stat_i.pos_zero ? ST_RESP : ST_SU_CMP;
      ST_SU_CMP: state_d = stat_i.su_move ? ST_SU_RD : ST_RESP;
      ST_SD_RD:  state_d = stat_i.sd_leaf ? ST_RESP : ST_SD_CMP;
      ST_SD_CMP: state_d = stat_i.sd_move ? ST_SD_RD : ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    ctl_o.op     = DP_NOP;
    ctl_o.status = STAT_OK;
    in_ready_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (command_i)
            CMD_PUSH: begin
              if (stat_i.full) begin
                ctl_o.op     = DP_FINISH;
                ctl_o.status = STAT_FULL;
              end else begin
                ctl_o.op = DP_PUSH_START;
              end
            end
            CMD_POP, CMD_PEEK: begin
              if (stat_i.empty) begin
                ctl_o.op     = DP_FINISH;
                ctl_o.status = STAT_EMPTY;
              end else begin
                ctl_o.op = DP_READ_ROOT;
              end
            end
            default: ctl_o.op = DP_FINISH;
          endcase
        end
      end
      ST_ROOT:   ctl_o.op = is_pop_q ? DP_POP_TAKE : DP_PEEK_TAKE;
      ST_SU_RD:  ctl_o.op = stat_i.pos_zero ? DP_WRITE_CUR : DP_SU_READ;
      ST_SU_CMP: ctl_o.op = DP_SU_STEP;
      ST_SD_RD:  ctl_o.op = stat_i.sd_leaf ? DP_WRITE_CUR : DP_SD_READ;
      ST_SD_CMP: ctl_o.op = DP_SD_STEP;
      ST_RESP: begin
        if (out_free) begin
          ctl_o.op = DP_LOAD_OUT;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_d = (ctl_o.op == DP_LOAD_OUT) || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      is_pop_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      is_pop_q    <= is_pop_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### sv/binary_min_heap_priority_queue.sv
`timescale 1ns / 1ps
// Top level of the bounded binary min-heap priority queue.
// Instantiates bmh_ctrl and bmh_datapath; depends on bmh_pkg.
//
//   Channel  Handshake             Word fields
//   -------  --------------------  --------------------------------------
//   input    in_valid_i/in_ready_o  command_i, key_in_i
//   output   out_valid_o/out_ready_i key_out_o, status_o, entry_count_o
//
// A push sifts up and a pop sifts down by at most six levels, each level a
// read and then a compare; a peek reads the root only, and a refused or
// unknown command goes straight to the response. The finished word sits in an
// output register, so a new word is taken while it waits; a stalled output
// then holds the next result and with it the input. Reset empties the heap at
// once; the key memory itself is not cleared.

module binary_min_heap_priority_queue (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          command_i,
  input  logic signed [bmh_pkg::KEY_IO_W-1:0] key_in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [bmh_pkg::KEY_IO_W-1:0] key_out_o,
  output logic [1:0]                          status_o,
  output logic [bmh_pkg::COUNT_IO_W-1:0]      entry_count_o
);
  import bmh_pkg::*;

  ctl_t     ctl;
  dp_stat_t dp_stat;

  bmh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (dp_stat),
    .ctl_o       (ctl)
  );

  bmh_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .key_in_i      (key_in_i),
    .stat_o        (dp_stat),
    .key_out_o     (key_out_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

`ifndef SYNTHESIS
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_FULL) |-> entry_count_o == COUNT_IO_W'(CAPACITY))
    else $error("full status with a count below capacity");

  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_EMPTY) |-> (entry_count_o == '0) && (key_out_o == '0))
    else $error("empty status with a nonzero count or key");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> entry_count_o <= COUNT_IO_W'(CAPACITY))
    else $error("entry count above capacity");

  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (command_i != CMD_PEEK) |=> !in_ready_o)
    else $error("input ready while a command is still in progress");
`endif

endmodule
